### hdl/gbs_pkg.sv
package gbs_pkg;

  localparam int unsigned NUM_COMPONENTS_DEF = 3;
  localparam int unsigned MAX_PIXELS_DEF     = 524288;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DEV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [15:0] LEARN_RATE_RST = 16'd6554;
  localparam logic [7:0]  MATCH_THR_RST  = 8'd56;
  localparam logic [15:0] INIT_DEV_RST   = 16'd1536;
  localparam logic [10:0] FRAME_W_RST    = 11'd640;
  localparam logic [9:0]  FRAME_H_RST    = 10'd480;

  localparam logic [1:0]  NO_MATCH         = 2'd3;
  localparam logic [16:0] LOG2E_Q16        = 17'd94548;
  localparam logic [14:0] INV_SQRT_2PI_Q16 = 15'd26145;
  localparam logic [16:0] ONE_Q16          = 17'h10000;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_STEP,
    OP_SQUARE,
    OP_DIV_Z,
    OP_EXP_MUL,
    OP_EXP_TAB,
    OP_EXP_SHIFT,
    OP_RHO_MUL1,
    OP_RHO_MUL2,
    OP_DIV_RHO,
    OP_RHO_SAT,
    OP_MEAN_MUL,
    OP_MEAN_SUM,
    OP_VAR_SQ,
    OP_VAR_MUL1,
    OP_VAR_MUL2,
    OP_VAR_SUM,
    OP_SQRT,
    OP_WRITE,
    OP_OUT_LOAD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hit;
    logic div_done;
    logic sqrt_done;
  } status_t;

  // 2^(-i/16) in Q1.16
  function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/gmm_background_subtractor_top.sv
// Per-pixel Gaussian mixture background subtractor for 8-bit grey video in
// raster order. Each pixel position keeps NUM_COMPONENTS components (weight
// Q0.16, mean and deviation Q8.8) in an on-chip store of MAX_PIXELS entries.
// After reset the block sweeps the store to its initial model, one entry per
// cycle over all MAX_PIXELS entries, and accepts no pixel during that sweep
// (configuration writes still land). One pixel is handled at a time: the store
// is read at the accepting edge. A pixel that matches no component then goes
// through match test and weight decay (one component per cycle), a branch
// state, write-back and result load, after which the next pixel can be taken.
// A matched pixel also passes, between branch and write-back, two runs of the
// bit-serial divider (exponent argument and learning rate) and the bit-serial
// square root of the new variance, with the multiply, table and sum steps
// around them. A finished result waits in an output register; the next pixel
// is taken once that result has been loaded.
// Result tdata bit 0 is the foreground flag, bits 2:1 the matched component
// (3 = none); tlast marks the last pixel of the frame.
module gmm_background_subtractor_top #(
  parameter int unsigned NUM_COMPONENTS = gbs_pkg::NUM_COMPONENTS_DEF,
  parameter int unsigned MAX_PIXELS     = gbs_pkg::MAX_PIXELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel_value
  input  logic                           s_axis_tuser,  // [0] frame_start
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [0] foreground, [2:1] matched_component
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gbs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one state per arithmetic step, waits on divider and root
  gbs_ctrl #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // store, configuration registers and arithmetic
  gbs_datapath #(
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .MAX_PIXELS     (MAX_PIXELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_data_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );
endmodule

### hdl/gbs_divider.sv
module gbs_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quotient_o
);
  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [47:0] quo_q;
  logic [32:0] rem_q, dsr_q;
  logic [33:0] trial;
  logic [33:0] diff;

  assign trial = {rem_q, quo_q[47]};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd47;
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_q <= diff[32:0];
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= trial[32:0];
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

### hdl/gbs_sqrt.sv
module gbs_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] radicand_i,
  output logic        done_o,
  output logic [15:0] root_o
);
  logic        busy_q, done_q;
  logic [3:0]  cnt_q;
  logic [31:0] rad_q;
  logic [15:0] root_q;
  logic [17:0] rem_q;
  logic [19:0] cur, trial, diff;

  assign cur   = {rem_q, rad_q[31:30]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = cur - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd15;
      end else if (busy_q) begin
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 4'd1;
        end
      end
    end
  end

  // one root bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[29:0], 2'b00};
      if (cur >= trial) begin
        rem_q  <= diff[17:0];
        root_q <= {root_q[14:0], 1'b1};
      end else begin
        rem_q  <= cur[17:0];
        root_q <= {root_q[14:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

### hdl/gbs_datapath.sv
module gbs_datapath #(
  parameter int unsigned NUM_COMPONENTS = gbs_pkg::NUM_COMPONENTS_DEF,
  parameter int unsigned MAX_PIXELS     = gbs_pkg::MAX_PIXELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gbs_pkg::cmd_t                  cmd_i,
  output gbs_pkg::status_t               status_o,
  input  logic [7:0]                     pixel_i,
  input  logic                           frame_start_i,
  input  logic                           cfg_we_i,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [7:0]                     out_data_o,
  output logic                           out_last_o
);
  import gbs_pkg::*;

  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned K_W    = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int unsigned ENT_W  = NUM_COMPONENTS * 48;
  localparam int unsigned W0     = 65536 / NUM_COMPONENTS;
  localparam logic [15:0] W_RST  = (W0 > 65535) ? 16'hFFFF : 16'(W0);
  localparam logic [20:0] MAX_TOT  = 21'(MAX_PIXELS);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_PIXELS - 1);

  // configuration
  logic [15:0] lr_q, init_dev_q;
  logic [7:0]  thr_q;
  logic [10:0] fw_q;
  logic [9:0]  fh_q;

  // control
  logic [ADDR_W-1:0] clr_q, raster_q, pos_q;
  logic [1:0]        hit_q;

  // model store
  logic [ENT_W-1:0] mem_q [MAX_PIXELS];
  logic [ENT_W-1:0] rd_q, wr_ent, rst_ent;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [ENT_W-1:0] mem_wd;

  logic [15:0] w_old [NUM_COMPONENTS];
  logic [15:0] m_old [NUM_COMPONENTS];
  logic [15:0] s_old [NUM_COMPONENTS];
  logic [15:0] wn_q  [NUM_COMPONENTS];

  // item
  logic [7:0]  pix_q;
  logic [15:0] x;
  logic        end_q;
  logic [15:0] mh_q, sh_q, dh_q;

  // arithmetic pipeline registers
  logic [31:0] s2_q, dsq_q;
  logic [36:0] p_q;
  logic        big_q;
  logic [4:0]  n_q;
  logic [16:0] base_q;
  logic [23:0] prod_q;
  logic [16:0] ex_q;
  logic [30:0] ac_q;
  logic [47:0] num_q;
  logic [16:0] rho_q;
  logic [32:0] pm1_q, pm2_q;
  logic [15:0] mn_q;
  logic [31:0] dd_q;
  logic [48:0] pv1_q, pv2_q;
  logic [31:0] var_q;

  // output
  logic       fg_q, last_q;
  logic [1:0] mc_q;

  // raster
  logic [ADDR_W-1:0] pos_cur;
  logic [20:0]       fsize, total, pos1;
  logic              end_cur;

  assign fsize   = fw_q * fh_q;
  assign total   = (fsize == 21'd0) ? 21'd1 : ((fsize > MAX_TOT) ? MAX_TOT : fsize);
  assign pos_cur = frame_start_i ? '0 : raster_q;
  assign pos1    = 21'(pos_cur) + 21'd1;
  assign end_cur = (pos1 >= total);

  assign x = {pix_q, 8'h00};

  for (genvar g = 0; g < NUM_COMPONENTS; g++) begin : g_lane
    assign w_old[g] = rd_q[g*48 +: 16];
    assign m_old[g] = rd_q[g*48+16 +: 16];
    assign s_old[g] = rd_q[g*48+32 +: 16];
    assign rst_ent[g*48 +: 48] = {INIT_DEV_RST, 16'h0000, W_RST};
  end

  // per-component step
  logic [K_W-1:0] kk;
  logic [15:0]    w_k, m_k, s_k, d_k, dec_k, whit_k;
  logic [16:0]    inv_a, sum_k;
  logic [32:0]    dec_prod;
  logic [23:0]    thr_s;
  logic           match_k, take_k;

  always_comb begin
    kk       = cmd_i.k[K_W-1:0];
    w_k      = w_old[kk];
    m_k      = m_old[kk];
    s_k      = s_old[kk];
    d_k      = (x > m_k) ? (x - m_k) : (m_k - x);
    inv_a    = ONE_Q16 - {1'b0, lr_q};
    dec_prod = w_k * inv_a;
    dec_k    = dec_prod[31:16];
    sum_k    = {1'b0, dec_k} + {1'b0, lr_q};
    whit_k   = sum_k[16] ? 16'hFFFF : sum_k[15:0];
    thr_s    = thr_q * s_k;
    match_k  = ({4'b0000, d_k, 4'b0000} < thr_s);
    take_k   = (hit_q == NO_MATCH) && match_k;
  end

  // exponent and update arithmetic
  logic [16:0] tab_a, tab_b, tab_diff, ex_v, inv_rho;
  logic [15:0] d2;
  logic [33:0] mean_sum;
  logic [49:0] var_sum;
  logic [4:0]  tab_idx;

  always_comb begin
    tab_idx  = {1'b0, p_q[31:28]};
    tab_a    = pow2_neg(tab_idx);
    tab_b    = pow2_neg(tab_idx + 5'd1);
    tab_diff = tab_a - tab_b;
    ex_v     = base_q - {5'b00000, prod_q[23:12]};
    inv_rho  = ONE_Q16 - rho_q;
    d2       = (x > mn_q) ? (x - mn_q) : (mn_q - x);
    mean_sum = {1'b0, pm1_q} + {1'b0, pm2_q} + 34'd32768;
    var_sum  = {1'b0, pv1_q} + {1'b0, pv2_q};
  end

  // divider and square root units
  logic        div_start, div_done, sqrt_start, sqrt_done;
  logic [47:0] div_num, quo;
  logic [32:0] div_den;
  logic [15:0] root;

  assign div_start  = (cmd_i.op == OP_DIV_Z) || (cmd_i.op == OP_DIV_RHO);
  assign div_num    = (cmd_i.op == OP_DIV_Z) ? {dsq_q, 16'h0000} : {24'h000000, num_q[47:24]};
  assign div_den    = (cmd_i.op == OP_DIV_Z) ? {s2_q, 1'b0} : {17'h00000, sh_q};
  assign sqrt_start = (cmd_i.op == OP_SQRT);

  gbs_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  gbs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (var_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // lowest weight and write-back entry
  logic [K_W-1:0] lo;
  always_comb begin
    lo = '0;
    for (int i = 1; i < NUM_COMPONENTS; i++) begin
      if (wn_q[i] < wn_q[lo]) lo = K_W'(i);
    end
    wr_ent = rd_q;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      wr_ent[i*48 +: 16] = wn_q[i];
      if (hit_q == 2'(i)) begin
        wr_ent[i*48+16 +: 16] = mn_q;
        wr_ent[i*48+32 +: 16] = root;
      end else if ((hit_q == NO_MATCH) && (lo == K_W'(i))) begin
        wr_ent[i*48+16 +: 16] = x;
        wr_ent[i*48+32 +: 16] = init_dev_q;
      end
    end
  end

  assign mem_we = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_WRITE);
  assign mem_wa = (cmd_i.op == OP_CLEAR) ? clr_q : pos_q;
  assign mem_wd = (cmd_i.op == OP_CLEAR) ? rst_ent : wr_ent;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (cmd_i.op == OP_ACCEPT) rd_q <= mem_q[pos_cur];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= LEARN_RATE_RST;
      thr_q      <= MATCH_THR_RST;
      init_dev_q <= INIT_DEV_RST;
      fw_q       <= FRAME_W_RST;
      fh_q       <= FRAME_H_RST;
      clr_q      <= '0;
      raster_q   <= '0;
      hit_q      <= NO_MATCH;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_LEARN_RATE:   lr_q       <= cfg_data_i;
          REG_MATCH_THR:    thr_q      <= cfg_data_i[7:0];
          REG_INIT_DEV:     init_dev_q <= cfg_data_i;
          REG_FRAME_WIDTH:  fw_q       <= cfg_data_i[10:0];
          REG_FRAME_HEIGHT: fh_q       <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (cmd_i.op == OP_ACCEPT) begin
        raster_q <= end_cur ? '0 : pos1[ADDR_W-1:0];
        hit_q    <= NO_MATCH;
      end
      if ((cmd_i.op == OP_STEP) && take_k) hit_q <= cmd_i.k;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        pix_q <= pixel_i;
        pos_q <= pos_cur;
        end_q <= end_cur;
      end
      OP_STEP: begin
        if (take_k) begin
          wn_q[kk] <= whit_k;
          mh_q     <= m_k;
          sh_q     <= s_k;
          dh_q     <= d_k;
        end else begin
          wn_q[kk] <= dec_k;
        end
      end
      OP_SQUARE: begin
        s2_q  <= sh_q * sh_q;
        dsq_q <= dh_q * dh_q;
      end
      OP_EXP_MUL: begin
        big_q <= |quo[47:20];
        p_q   <= quo[19:0] * LOG2E_Q16;
      end
      OP_EXP_TAB: begin
        n_q    <= p_q[36:32];
        base_q <= tab_a;
        prod_q <= tab_diff[11:0] * p_q[27:16];
      end
      OP_EXP_SHIFT: ex_q <= (big_q || (n_q >= 5'd17)) ? 17'd0 : (ex_v >> n_q);
      OP_RHO_MUL1:  ac_q <= lr_q * INV_SQRT_2PI_Q16;
      OP_RHO_MUL2:  num_q <= ac_q * ex_q;
      OP_RHO_SAT:   rho_q <= (quo > 48'(ONE_Q16)) ? ONE_Q16 : quo[16:0];
      OP_MEAN_MUL: begin
        pm1_q <= inv_rho * mh_q;
        pm2_q <= rho_q * x;
      end
      OP_MEAN_SUM:  mn_q  <= mean_sum[31:16];
      OP_VAR_SQ:    dd_q  <= d2 * d2;
      OP_VAR_MUL1:  pv1_q <= inv_rho * s2_q;
      OP_VAR_MUL2:  pv2_q <= rho_q * dd_q;
      OP_VAR_SUM:   var_q <= var_sum[47:16];
      OP_OUT_LOAD: begin
        fg_q   <= (hit_q == NO_MATCH);
        mc_q   <= hit_q;
        last_q <= end_q;
      end
      default: ;
    endcase
  end

  assign status_o.clear_last = (clr_q == CLR_LAST);
  assign status_o.hit        = (hit_q != NO_MATCH);
  assign status_o.div_done   = div_done;
  assign status_o.sqrt_done  = sqrt_done;

  assign out_data_o = {5'b00000, mc_q, fg_q};
  assign out_last_o = last_q;

`ifndef SYNTHESIS
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q == NO_MATCH) || (32'(hit_q) < NUM_COMPONENTS))
    else $error("matched index beyond component count");
  a_hit_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_ACCEPT) |=> (hit_q == NO_MATCH))
    else $error("match not cleared on a new item");
  a_rho_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RHO_SAT) |=> (rho_q <= ONE_Q16))
    else $error("rate above one");
`endif
endmodule

### hdl/gbs_ctrl.sv
module gbs_ctrl #(
  parameter int unsigned NUM_COMPONENTS = gbs_pkg::NUM_COMPONENTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gbs_pkg::cmd_t    cmd_o,
  input  gbs_pkg::status_t status_i
);
  import gbs_pkg::*;

  localparam logic [1:0] K_LAST = 2'(NUM_COMPONENTS - 1);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_STEP   = 5'd2;
  localparam logic [4:0] S_BRANCH = 5'd3;
  localparam logic [4:0] S_SQUARE = 5'd4;
  localparam logic [4:0] S_DIVZ   = 5'd5;
  localparam logic [4:0] S_DIVZ_W = 5'd6;
  localparam logic [4:0] S_EXP1   = 5'd7;
  localparam logic [4:0] S_EXP2   = 5'd8;
  localparam logic [4:0] S_EXP3   = 5'd9;
  localparam logic [4:0] S_RHO1   = 5'd10;
  localparam logic [4:0] S_RHO2   = 5'd11;
  localparam logic [4:0] S_DIVR   = 5'd12;
  localparam logic [4:0] S_DIVR_W = 5'd13;
  localparam logic [4:0] S_RHO3   = 5'd14;
  localparam logic [4:0] S_MEAN1  = 5'd15;
  localparam logic [4:0] S_MEAN2  = 5'd16;
  localparam logic [4:0] S_VAR1   = 5'd17;
  localparam logic [4:0] S_VAR2   = 5'd18;
  localparam logic [4:0] S_VAR3   = 5'd19;
  localparam logic [4:0] S_VAR4   = 5'd20;
  localparam logic [4:0] S_SQRT   = 5'd21;
  localparam logic [4:0] S_SQRT_W = 5'd22;
  localparam logic [4:0] S_WRITE  = 5'd23;
  localparam logic [4:0] S_OUT    = 5'd24;

  logic [4:0] state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       ovalid_q, ovalid_d;
  logic       in_fire, out_load;

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cmd_o.op   = OP_NOP;
    cmd_o.k    = k_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          k_d      = 2'd0;
          state_d  = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.op = OP_STEP;
        if (k_q == K_LAST) state_d = S_BRANCH;
        else k_d = k_q + 2'd1;
      end
      S_BRANCH: state_d = status_i.hit ? S_SQUARE : S_WRITE;
      S_SQUARE: begin
        cmd_o.op = OP_SQUARE;
        state_d  = S_DIVZ;
      end
      S_DIVZ: begin
        cmd_o.op = OP_DIV_Z;
        state_d  = S_DIVZ_W;
      end
      S_DIVZ_W: if (status_i.div_done) state_d = S_EXP1;
      S_EXP1: begin
        cmd_o.op = OP_EXP_MUL;
        state_d  = S_EXP2;
      end
      S_EXP2: begin
        cmd_o.op = OP_EXP_TAB;
        state_d  = S_EXP3;
      end
      S_EXP3: begin
        cmd_o.op = OP_EXP_SHIFT;
        state_d  = S_RHO1;
      end
      S_RHO1: begin
        cmd_o.op = OP_RHO_MUL1;
        state_d  = S_RHO2;
      end
      S_RHO2: begin
        cmd_o.op = OP_RHO_MUL2;
        state_d  = S_DIVR;
      end
      S_DIVR: begin
        cmd_o.op = OP_DIV_RHO;
        state_d  = S_DIVR_W;
      end
      S_DIVR_W: if (status_i.div_done) state_d = S_RHO3;
      S_RHO3: begin
        cmd_o.op = OP_RHO_SAT;
        state_d  = S_MEAN1;
      end
      S_MEAN1: begin
        cmd_o.op = OP_MEAN_MUL;
        state_d  = S_MEAN2;
      end
      S_MEAN2: begin
        cmd_o.op = OP_MEAN_SUM;
        state_d  = S_VAR1;
      end
      S_VAR1: begin
        cmd_o.op = OP_VAR_SQ;
        state_d  = S_VAR2;
      end
      S_VAR2: begin
        cmd_o.op = OP_VAR_MUL1;
        state_d  = S_VAR3;
      end
      S_VAR3: begin
        cmd_o.op = OP_VAR_MUL2;
        state_d  = S_VAR4;
      end
      S_VAR4: begin
        cmd_o.op = OP_VAR_SUM;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        state_d  = S_SQRT_W;
      end
      S_SQRT_W: if (status_i.sqrt_done) state_d = S_WRITE;
      S_WRITE: begin
        cmd_o.op = OP_WRITE;
        state_d  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!ovalid_q || out_ready_i) begin
          cmd_o.op = OP_OUT_LOAD;
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_fire  = in_ready_o && in_valid_i;
  assign ovalid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : ovalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

`ifndef SYNTHESIS
  a_accept_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_STEP) && (k_q == 2'd0))
    else $error("accepted item did not start the component walk");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (k_q <= K_LAST))
    else $error("component index out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && ovalid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("result loaded over a waiting result");
`endif
endmodule

### test/tb_top.sv
module tb_top;
  import gbs_pkg::*;

  // Shrink the pixel store so that the clearing sweep after reset and each
  // frame stay short; frame sizes above it saturate.
  localparam int unsigned NCOMP = 3;
  localparam int unsigned NPIX  = 256;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic       foreground;
    logic [1:0] component;
    logic       frame_end;
  } mask_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  gmm_background_subtractor_top #(
    .NUM_COMPONENTS(NCOMP),
    .MAX_PIXELS    (NPIX)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] pixel_value
    .s_axis_tuser (s_axis_tuser),   // [0] frame_start
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [0] foreground, [2:1] matched_component
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Background model mirror: own copy of the per-pixel mixtures and registers
  // ---------------------------------------------------------------------------
  logic [15:0] mix_weight [NCOMP][NPIX];
  logic [15:0] mix_mean   [NCOMP][NPIX];
  logic [15:0] mix_dev    [NCOMP][NPIX];
  logic [31:0] raster_pos;
  logic [15:0] alpha_q16;
  logic [7:0]  thr_q44;
  logic [15:0] init_dev_q88;
  logic [10:0] width_px;
  logic [9:0]  height_ln;

  // 2^(-i/16) in Q1.16
  logic [31:0] exp2_frac [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                  48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                  35734, 34219, 32768};

  function automatic logic [31:0] exp_neg_q16(logic [63:0] z);
    logic [63:0] t;
    logic [63:0] ipart;
    logic [31:0] f;
    logic [31:0] idx;
    logic [31:0] r;
    logic [31:0] v;
    if (z > 64'hFFFF_FFFF) return 0;
    t = (z * 64'(LOG2E_Q16)) >> 16;
    ipart = t >> 16;
    if (ipart >= 17) return 0;
    f = 32'(t[15:0]);
    idx = f >> 12;
    r = f & 32'hFFF;
    v = exp2_frac[idx] - (((exp2_frac[idx] - exp2_frac[idx+1]) * r) >> 12);
    return v >> ipart;
  endfunction

  function automatic logic [15:0] sqrt_sat(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return (res > 65535) ? 16'hFFFF : res[15:0];
  endfunction

  task automatic reset_model();
    logic [31:0] w0;
    w0 = 65536 / NCOMP;
    if (w0 > 65535) w0 = 65535;
    alpha_q16    = LEARN_RATE_RST;
    thr_q44      = MATCH_THR_RST;
    init_dev_q88 = INIT_DEV_RST;
    width_px     = FRAME_W_RST;
    height_ln    = FRAME_H_RST;
    raster_pos   = 0;
    for (int k = 0; k < NCOMP; k++)
      for (int p = 0; p < NPIX; p++) begin
        mix_weight[k][p] = w0[15:0];
        mix_mean[k][p]   = '0;
        mix_dev[k][p]    = INIT_DEV_RST;
      end
  endtask

  function automatic logic [31:0] frame_total();
    logic [31:0] tot;
    tot = 32'(width_px) * 32'(height_ln);
    if (tot == 0) tot = 1;
    if (tot > NPIX) tot = NPIX;
    return tot;
  endfunction

  // Advance the mixture of one pixel position and return its mask item.
  function automatic mask_item_t classify_pixel(pixel_item_t it);
    mask_item_t  res;
    logic [63:0] x;
    logic [63:0] a;
    logic [63:0] m;
    logic [63:0] s;
    logic [63:0] d;
    logic [63:0] w;
    logic [63:0] s2;
    logic [63:0] z;
    logic [63:0] rho;
    logic [63:0] mn;
    logic [63:0] d2;
    logic [63:0] var_q;
    logic [31:0] pos;
    logic [31:0] ex;
    logic [1:0]  hit;
    logic        last_px;
    int          lo;
    x = 64'(it.pixel) << 8;
    a = 64'(alpha_q16);
    hit = NO_MATCH;
    if (it.frame_start) raster_pos = 0;
    if (raster_pos >= NPIX) raster_pos = 0;
    pos = raster_pos;
    last_px = (pos + 1) >= frame_total();
    raster_pos = last_px ? 0 : pos + 1;

    for (int k = 0; k < NCOMP; k++) begin
      m = 64'(mix_mean[k][pos]);
      s = 64'(mix_dev[k][pos]);
      d = (x > m) ? x - m : m - x;
      if (hit == NO_MATCH && (d << 4) < 64'(thr_q44) * s) hit = 2'(k);
    end

    for (int k = 0; k < NCOMP; k++) begin
      w = (64'(mix_weight[k][pos]) * (65536 - a)) >> 16;
      if (2'(k) == hit) begin
        m = 64'(mix_mean[k][pos]);
        s = 64'(mix_dev[k][pos]);
        d = (x > m) ? x - m : m - x;
        s2 = s * s;
        w = w + a;
        if (w > 65535) w = 65535;
        // a zero deviation never matches, so s is nonzero here
        if (s != 0) begin
          z = ((d * d) << 16) / (2 * s2);
          ex = exp_neg_q16(z);
          rho = ((a * 64'(INV_SQRT_2PI_Q16) * 64'(ex)) << 8) / (s << 32);
          if (rho > 65536) rho = 65536;
          mn = ((65536 - rho) * m + rho * x + 32768) >> 16;
          d2 = (x > mn) ? x - mn : mn - x;
          var_q = ((65536 - rho) * s2 + rho * d2 * d2) >> 16;
          mix_mean[k][pos] = mn[15:0];
          mix_dev[k][pos]  = sqrt_sat(var_q);
        end
      end
      mix_weight[k][pos] = w[15:0];
    end

    // no match: replace the lightest component (lowest index on ties)
    if (hit == NO_MATCH) begin
      lo = 0;
      for (int k = 1; k < NCOMP; k++)
        if (mix_weight[k][pos] < mix_weight[lo][pos]) lo = k;
      mix_mean[lo][pos] = x[15:0];
      mix_dev[lo][pos]  = init_dev_q88;
    end

    res.foreground = (hit == NO_MATCH);
    res.component  = hit;
    res.frame_end  = last_px;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: pops pending items, inserts random idle bursts
  // ---------------------------------------------------------------------------
  pixel_item_t pending_pixels[$];
  mask_item_t  expected_masks[$];
  bit          quiet_mode = 1'b0;
  int          send_gap = 0;
  int          hold_gap = 0;
  int          n_fg = 0;
  int          n_match = 0;
  int          n_frame_end = 0;
  bit          failed = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // predict each accepted pixel as it is taken
      if (s_axis_tvalid && s_axis_tready)
        expected_masks.push_back(classify_pixel('{s_axis_tdata, s_axis_tuser}));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0 && !quiet_mode && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 7);
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          nxt = pending_pixels.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.pixel;
          s_axis_tuser  <= nxt.frame_start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Mask monitor: random back-pressure, compare against oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    mask_item_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_masks.size() == 0) begin
          $error("mask item with no pixel pending: tdata=%0h", m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = expected_masks.pop_front();
          if (m_axis_tdata[0] !== want.foreground) begin
            $error("foreground: expected %0d, got %0d", want.foreground, m_axis_tdata[0]);
            failed = 1'b1;
          end
          if (m_axis_tdata[2:1] !== want.component) begin
            $error("matched_component: expected %0d, got %0d", want.component,
                   m_axis_tdata[2:1]);
            failed = 1'b1;
          end
          if (m_axis_tlast !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, m_axis_tlast);
            failed = 1'b1;
          end
          if (want.foreground) n_fg++; else n_match++;
          if (want.frame_end) n_frame_end++;
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        hold_gap = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no item moves for too long
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stall_cycles <= 0;
    else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [7:0] bg_level [NPIX];
  int         n_items = 0;

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_LEARN_RATE:   alpha_q16    = val;
      REG_MATCH_THR:    thr_q44      = val[7:0];
      REG_INIT_DEV:     init_dev_q88 = val;
      REG_FRAME_WIDTH:  width_px     = val[10:0];
      REG_FRAME_HEIGHT: height_ln    = val[9:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold the sender until every mask item is back and the block has settled
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_pixels.size() != 0 || expected_masks.size() != 0 || s_axis_tvalid);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_pixel(logic [7:0] px, logic fs);
    pending_pixels.push_back('{px, fs});
    n_items++;
  endtask

  // Mostly background-like frames: each position sits near its own level,
  // with a share of outliers, restarts and missing frame starts.
  task automatic queue_video(int count, int spread);
    int tot;
    int p;
    int px;
    logic fs;
    tot = frame_total();
    p = 0;
    for (int i = 0; i < count; i++) begin
      fs = (p == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) == 0);
      if (fs) p = 0;
      if ($urandom_range(0, 4) == 0) px = $urandom_range(0, 255);
      else begin
        px = int'(bg_level[p]) + $urandom_range(0, 2 * spread) - spread;
        if (px < 0) px = 0;
        if (px > 255) px = 255;
      end
      queue_pixel(8'(px), fs);
      p = (p + 1 >= tot) ? 0 : p + 1;
    end
  endtask

  initial begin
    reset_model();
    foreach (bg_level[i]) bg_level[i] = 8'($urandom_range(0, 255));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, extreme pixels at the same positions,
    // frame start on and off, then a tiny frame.
    write_reg(REG_FRAME_WIDTH, 16'd2);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    end_writes();
    for (int i = 0; i < 4; i++) queue_pixel(8'd0, i == 0);
    for (int i = 0; i < 4; i++) queue_pixel(8'd255, 1'b0);
    for (int i = 0; i < 4; i++) queue_pixel(8'(i * 3), i == 2);
    queue_pixel(8'd255, 1'b1);
    queue_pixel(8'd128, 1'b1);
    wait_drained();

    // Extreme settings: no learning, threshold zero, smallest nonzero deviation,
    // one-pixel frame.
    write_reg(REG_LEARN_RATE, 16'd0);
    write_reg(REG_MATCH_THR, 16'd0);
    write_reg(REG_INIT_DEV, 16'd1);
    write_reg(REG_FRAME_WIDTH, 16'd1);
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    end_writes();
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b1);
    queue_pixel(8'd7, 1'b0);
    wait_drained();

    // Other extreme: full learning, widest threshold, largest deviation,
    // frame larger than the store.
    write_reg(REG_LEARN_RATE, 16'hFFFF);
    write_reg(REG_MATCH_THR, 16'd255);
    write_reg(REG_INIT_DEV, 16'hFFFF);
    write_reg(REG_FRAME_WIDTH, 16'd1024);
    write_reg(REG_FRAME_HEIGHT, 16'd512);
    end_writes();
    queue_pixel(8'd255, 1'b1);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd100, 1'b0);
    wait_drained();

    // Random phases with fresh register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0:       write_reg(REG_LEARN_RATE, ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0);
        default: write_reg(REG_LEARN_RATE, 16'($urandom_range(200, 20000)));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_MATCH_THR, ($urandom_range(0, 1) != 0) ? 16'd255 : 16'd0);
        default: write_reg(REG_MATCH_THR, 16'($urandom_range(16, 96)));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_INIT_DEV, ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1);
        default: write_reg(REG_INIT_DEV, 16'($urandom_range(256, 4096)));
      endcase
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_FRAME_WIDTH, 16'd1024);
        write_reg(REG_FRAME_HEIGHT, 16'd512);
      end else begin
        write_reg(REG_FRAME_WIDTH, 16'($urandom_range(1, 16)));
        write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(1, 4)));
      end
      end_writes();
      quiet_mode = (ph == 7);
      queue_video(200, $urandom_range(1, 12));
      wait_drained();
    end

    $display("Covered %0d pixels: %0d matched, %0d foreground, %0d frame ends,",
             n_items, n_match, n_fg, n_frame_end);
    $display("across extreme and random register settings with idle and stall bursts.");
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
